// ===== hw/rtl/rrfl_pkg.sv =====
// Package for the receive ring FIFO line reader.
// Holds action codes, result kinds and the controller/datapath interface structs.
// No dependencies.
package rrfl_pkg;

  localparam int unsigned LEN_W  = 6;
  localparam int unsigned MLEN_W = 16;

  localparam logic [1:0] ACT_RX   = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_LINE = 2'd2;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_LINE
  } state_t;

  typedef enum logic [2:0] {
    EK_PUSH,
    EK_POP,
    EK_CHAR,
    EK_TERM,
    EK_BLANK
  } emit_kind_t;

  typedef struct packed {
    logic       load;
    logic       push;
    logic       rd_issue;
    logic       count_inc;
    logic       emit;
    emit_kind_t kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       empty;
    logic       room;
    logic       eol;
    logic       count_zero;
    logic       out_free;
  } dp_sts_t;

endpackage

// ===== hw/rtl/rrfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/rrfl_ctrl.sv =====
// Controller state machine for the receive ring FIFO line reader.
// Depends on rrfl_pkg; drives commands to rrfl_dp from its status.
module rrfl_ctrl
  import rrfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.kind   = EK_BLANK;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.act)
          ACT_RX: begin
            if (sts.out_free) begin
              cmd.push   = 1'b1;
              cmd.emit   = 1'b1;
              cmd.kind   = EK_PUSH;
              state_next = ST_IDLE;
            end
          end
          ACT_POP: begin
            if (!sts.empty) begin
              cmd.rd_issue = 1'b1;
              state_next   = ST_POP;
            end else if (sts.out_free) begin
              cmd.emit   = 1'b1;
              cmd.kind   = EK_BLANK;
              state_next = ST_IDLE;
            end
          end
          ACT_LINE: begin
            if (sts.room && !sts.empty) begin
              cmd.rd_issue = 1'b1;
              state_next   = ST_LINE;
            end else if (sts.out_free) begin
              cmd.emit   = 1'b1;
              cmd.kind   = EK_TERM;
              state_next = ST_IDLE;
            end
          end
          default: begin
            if (sts.out_free) begin
              cmd.emit   = 1'b1;
              cmd.kind   = EK_BLANK;
              state_next = ST_IDLE;
            end
          end
        endcase
      end
      ST_POP: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EK_POP;
          state_next = ST_IDLE;
        end
      end
      ST_LINE: begin
        if (sts.eol) begin
          if (sts.count_zero) begin
            state_next = ST_EXEC;
          end else if (sts.out_free) begin
            cmd.emit   = 1'b1;
            cmd.kind   = EK_TERM;
            state_next = ST_IDLE;
          end
        end else if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = EK_CHAR;
          cmd.count_inc = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rrfl_dp.sv =====
// Datapath for the receive ring FIFO line reader: indices, byte store,
// line counter and output register. Depends on rrfl_pkg and rrfl_ram.
module rrfl_dp
  import rrfl_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output dp_sts_t           sts,
  input  logic [1:0]        in_act,
  input  logic [7:0]        in_byte,
  input  logic [MLEN_W-1:0] in_max_len,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              out_has_char,
  output logic              out_dropped,
  output logic [LEN_W-1:0]  out_len,
  output logic              out_last,
  output logic              out_not_empty
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam logic [AW-1:0] IDX_LAST = AW'(FIFO_DEPTH - 1);

  logic [1:0]        act;
  logic [7:0]        rx_byte;
  logic [MLEN_W-1:0] limit;
  logic [AW-1:0]     wr_idx, rd_idx, wr_idx_next, rd_idx_next;
  logic [LEN_W-1:0]  count;
  logic [7:0]        rdata;
  logic              empty, full, out_free, wr_en;

  assign wr_idx_next = (wr_idx == IDX_LAST) ? '0 : wr_idx + 1'b1;
  assign rd_idx_next = (rd_idx == IDX_LAST) ? '0 : rd_idx + 1'b1;
  assign empty       = (wr_idx == rd_idx);
  assign full        = (wr_idx_next == rd_idx);
  assign out_free    = !out_valid || out_ready;
  assign wr_en       = cmd.push && !full;

  assign sts.act        = act;
  assign sts.empty      = empty;
  assign sts.room       = MLEN_W'(count) < limit;
  assign sts.eol        = (rdata == CH_LF) || (rdata == CH_CR);
  assign sts.count_zero = (count == '0);
  assign sts.out_free   = out_free;

  rrfl_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_idx),
    .wdata(rx_byte),
    .re   (cmd.rd_issue),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act     <= in_act;
      rx_byte <= in_byte;
      limit   <= (in_max_len == '0) ? '0 : in_max_len - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_idx <= wr_idx_next;
      end
      if (cmd.rd_issue) begin
        rd_idx <= rd_idx_next;
      end
      if (cmd.load) begin
        count <= '0;
      end else if (cmd.count_inc) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char      <= CH_NUL;
      out_has_char  <= 1'b0;
      out_dropped   <= 1'b0;
      out_len       <= '0;
      out_last      <= 1'b1;
      out_not_empty <= !empty;
      case (cmd.kind)
        EK_PUSH: begin
          out_dropped   <= full;
          out_not_empty <= 1'b1;
        end
        EK_POP: begin
          out_char     <= rdata;
          out_has_char <= 1'b1;
        end
        EK_CHAR: begin
          out_char     <= rdata;
          out_has_char <= 1'b1;
          out_last     <= 1'b0;
        end
        EK_TERM: begin
          out_len <= count;
        end
        default: begin
          out_last <= 1'b1;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result emitted while output register busy");
  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> !empty)
    else $error("read issued on empty FIFO");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= LEN_W'(FIFO_DEPTH - 1))
    else $error("line count exceeds FIFO capacity");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (wr_idx <= IDX_LAST) && (rd_idx <= IDX_LAST))
    else $error("FIFO index out of range");
`endif

endmodule

// ===== hw/rtl/rx_ring_fifo_line_reader_top.sv =====
// Receive ring FIFO with line reader; depends on rrfl_pkg, rrfl_ctrl, rrfl_dp, rrfl_ram.
// A received byte, an empty pop or an undefined action is latched from the input beat, then
// its result is registered; a pop or line read that takes a byte issues the RAM read, then
// registers the RAM data. A new input beat is accepted only once the last result is
// registered; a line read walks the FIFO byte by byte, waiting while the output is full.
// Reset (rst, synchronous) empties the FIFO, clears the output valid flag, holds s_tready low.
module rx_ring_fifo_line_reader_top
  import rrfl_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // rx_byte[7:0], max_len[23:8]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // char_out[7:0], has_char[8], dropped[9],
                                 // line_length[15:10], not_empty[16], zero[23:17]
  output logic        m_tlast
);

  ctrl_cmd_t        cmd;
  dp_sts_t          sts;
  logic [7:0]       out_char;
  logic             out_has_char, out_dropped, out_not_empty;
  logic [LEN_W-1:0] out_len;

  rrfl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  rrfl_dp #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_act       (s_tuser),
    .in_byte      (s_tdata[7:0]),
    .in_max_len   (s_tdata[23:8]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_char     (out_char),
    .out_has_char (out_has_char),
    .out_dropped  (out_dropped),
    .out_len      (out_len),
    .out_last     (m_tlast),
    .out_not_empty(out_not_empty)
  );

  assign m_tdata = {7'd0, out_not_empty, out_len, out_dropped, out_has_char, out_char};

endmodule

// ===== tb/tb.sv =====
// Testbench for rx_ring_fifo_line_reader_top: directed table, then random stream traffic.
// Every result beat is checked against a local model of the ring FIFO and its line reader.
// Depends on rrfl_pkg and the RTL under hw/rtl.
module tb
  import rrfl_pkg::*;
();

  localparam logic [1:0] ACT_UNDEF = 2'd3;
  localparam int unsigned NROWS = 24;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       drop;
    logic [5:0] len;
    logic       last;
    logic       ne;
  } beat_t;

  typedef struct packed {
    logic [1:0]  act;
    logic [7:0]  b;
    logic [15:0] ml;
    logic        typed;
    beat_t       want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // rx_byte[7:0], max_len[23:8]
  logic [1:0]  s_tuser = '0;  // action[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;       // char_out[7:0], has_char[8], dropped[9], line_length[15:10],
                              // not_empty[16]
  logic        m_tlast;

  logic [7:0]  fifo_mem [64];
  logic [5:0]  wr_idx = '0;
  logic [5:0]  rd_idx = '0;
  beat_t       due_beats [$];
  int          errors = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          lines_read = 0;
  int          drops = 0;
  int          hold_left = 0;
  bit          held_once = 1'b0;
  int          sent = 0;
  stim_row_t   rows [NROWS];

  rx_ring_fifo_line_reader_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void queue_beat(logic [7:0] ch, logic has, logic drop, logic [5:0] len,
                                     logic last);
    beat_t e;
    e.ch = ch;
    e.has = has;
    e.drop = drop;
    e.len = len;
    e.last = last;
    e.ne = (wr_idx != rd_idx);
    due_beats.push_back(e);
  endfunction

  function automatic void apply_action(logic [1:0] act, logic [7:0] b, logic [15:0] ml);
    logic [15:0] limit;
    logic [6:0]  count;
    logic [7:0]  c;
    bit          done;
    case (act)
      ACT_RX: begin
        if (wr_idx + 6'd1 != rd_idx) begin
          fifo_mem[wr_idx] = b;
          wr_idx = wr_idx + 6'd1;
          queue_beat(CH_NUL, 1'b0, 1'b0, 6'd0, 1'b1);
        end else begin
          drops++;
          queue_beat(CH_NUL, 1'b0, 1'b1, 6'd0, 1'b1);
        end
      end
      ACT_POP: begin
        if (wr_idx != rd_idx) begin
          c = fifo_mem[rd_idx];
          rd_idx = rd_idx + 6'd1;
          queue_beat(c, 1'b1, 1'b0, 6'd0, 1'b1);
        end else begin
          queue_beat(CH_NUL, 1'b0, 1'b0, 6'd0, 1'b1);
        end
      end
      ACT_LINE: begin
        lines_read++;
        limit = (ml == 16'd0) ? 16'd0 : ml - 16'd1;
        count = '0;
        done = 1'b0;
        while (!done && count < limit && wr_idx != rd_idx) begin
          c = fifo_mem[rd_idx];
          rd_idx = rd_idx + 6'd1;
          if (c == CH_LF || c == CH_CR) begin
            if (count != 0) done = 1'b1;
          end else begin
            queue_beat(c, 1'b1, 1'b0, 6'd0, 1'b0);
            count++;
          end
        end
        queue_beat(CH_NUL, 1'b0, 1'b0, count[5:0], 1'b1);
      end
      default: queue_beat(CH_NUL, 1'b0, 1'b0, 6'd0, 1'b1);
    endcase
  endfunction

  task automatic offer(logic [1:0] act, logic [7:0] b, logic [15:0] ml, logic typed,
                       beat_t want);
    while (!(sent >= 130 && sent < 200) && $urandom_range(0, 99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ml, b};
    s_tuser <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    apply_action(act, b, ml);
    if (typed) begin
      void'(due_beats.pop_back());
      due_beats.push_back(want);
    end
  endtask

  task automatic offer_plain(logic [1:0] act, logic [7:0] b, logic [15:0] ml);
    offer(act, b, ml, 1'b0, '0);
  endtask

  // input beat counter and receiver back-pressure, with one long hold-off
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) beats_in <= beats_in + 1;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held_once && beats_in >= 60) begin
      held_once <= 1'b1;
      hold_left <= 300;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (beats_out >= 250 && beats_out < 450) || ($urandom_range(0, 99) >= 7);
    end
  end

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      beats_out <= beats_out + 1;
      got.ch = m_tdata[7:0];
      got.has = m_tdata[8];
      got.drop = m_tdata[9];
      got.len = m_tdata[15:10];
      got.last = m_tlast;
      got.ne = m_tdata[16];
      if (due_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat ch=%h has=%b drop=%b len=%0d last=%b ne=%b", $time,
                 got.ch, got.has, got.drop, got.len, got.last, got.ne);
      end else begin
        want = due_beats.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch exp ch=%h has=%b drop=%b len=%0d last=%b ne=%b", $time,
                   want.ch, want.has, want.drop, want.len, want.last, want.ne);
          $display("%0t:          got ch=%h has=%b drop=%b len=%0d last=%b ne=%b", $time,
                   got.ch, got.has, got.drop, got.len, got.last, got.ne);
        end
      end
    end
  end

  initial begin
    #(12 * 400000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int n;
    int r;
    bit filled;
    rows = '{
      '{ACT_POP,   8'h00, 16'h0000, 1'b1, '{8'h00, 1'b0, 1'b0, 6'd0, 1'b1, 1'b0}},
      '{ACT_LINE,  8'h00, 16'h0000, 1'b1, '{8'h00, 1'b0, 1'b0, 6'd0, 1'b1, 1'b0}},
      '{ACT_UNDEF, 8'hFF, 16'hFFFF, 1'b1, '{8'h00, 1'b0, 1'b0, 6'd0, 1'b1, 1'b0}},
      '{ACT_RX,    8'h00, 16'hFFFF, 1'b1, '{8'h00, 1'b0, 1'b0, 6'd0, 1'b1, 1'b1}},
      '{ACT_RX,    8'hFF, 16'h0000, 1'b1, '{8'h00, 1'b0, 1'b0, 6'd0, 1'b1, 1'b1}},
      '{ACT_POP,   8'hFF, 16'hFFFF, 1'b1, '{8'h00, 1'b1, 1'b0, 6'd0, 1'b1, 1'b1}},
      '{ACT_POP,   8'h00, 16'h0000, 1'b1, '{8'hFF, 1'b1, 1'b0, 6'd0, 1'b1, 1'b0}},
      '{ACT_RX,    CH_CR, 16'h0000, 1'b0, '0},
      '{ACT_RX,    CH_LF, 16'h0000, 1'b0, '0},
      '{ACT_RX,    8'h41, 16'h0000, 1'b0, '0},
      '{ACT_RX,    CH_CR, 16'h0000, 1'b0, '0},
      '{ACT_RX,    8'h42, 16'h0000, 1'b0, '0},
      '{ACT_LINE,  8'h00, 16'hFFFF, 1'b0, '0},
      '{ACT_LINE,  8'h00, 16'h0001, 1'b0, '0},
      '{ACT_UNDEF, 8'h00, 16'h0000, 1'b1, '{8'h00, 1'b0, 1'b0, 6'd0, 1'b1, 1'b1}},
      '{ACT_LINE,  8'h00, 16'h0002, 1'b0, '0},
      '{ACT_RX,    CH_LF, 16'h0000, 1'b0, '0},
      '{ACT_RX,    CH_CR, 16'h0000, 1'b0, '0},
      '{ACT_LINE,  8'h00, 16'h0005, 1'b0, '0},
      '{ACT_RX,    8'h55, 16'h0000, 1'b0, '0},
      '{ACT_RX,    8'hAA, 16'h0000, 1'b0, '0},
      '{ACT_LINE,  8'h00, 16'h0000, 1'b0, '0},
      '{ACT_LINE,  8'h00, 16'h0003, 1'b0, '0},
      '{ACT_POP,   8'h00, 16'h0000, 1'b1, '{8'h00, 1'b0, 1'b0, 6'd0, 1'b1, 1'b0}}
    };
    filled = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) offer(rows[i].act, rows[i].b, rows[i].ml, rows[i].typed, rows[i].want);

    while (sent < 220) begin
      if (!filled && sent >= 110) begin
        // drain, then overfill so the next line read walks the whole store
        filled = 1'b1;
        while (wr_idx != rd_idx) offer_plain(ACT_POP, 8'($urandom), 16'($urandom));
        repeat (66) offer_plain(ACT_RX, 8'($urandom_range(8'h20, 8'hFF)), 16'($urandom));
        offer_plain(ACT_LINE, 8'($urandom), 16'hFFFF);
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        n = $urandom_range(1, 12);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) offer_plain(ACT_RX, 8'($urandom), 16'($urandom));
          else offer_plain(ACT_RX, 8'($urandom_range(8'h20, 8'h7E)), 16'($urandom));
        end
        case ($urandom_range(0, 2))
          0: offer_plain(ACT_RX, CH_CR, 16'($urandom));
          1: offer_plain(ACT_RX, CH_LF, 16'($urandom));
          default: begin
            offer_plain(ACT_RX, CH_CR, 16'($urandom));
            offer_plain(ACT_RX, CH_LF, 16'($urandom));
          end
        endcase
        if ($urandom_range(0, 4) == 0) offer_plain(ACT_LINE, 8'($urandom), 16'($urandom));
        else offer_plain(ACT_LINE, 8'($urandom), 16'($urandom_range(0, 20)));
      end else if (r < 85) begin
        repeat ($urandom_range(1, 3)) offer_plain(ACT_POP, 8'($urandom), 16'($urandom));
      end else begin
        offer_plain(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    while (due_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("tb: %0d input beats, %0d result beats, %0d line reads, %0d dropped bytes",
             sent, beats_out, lines_read, drops);
    $display("tb: covered empty pops, leading and trailing CR/LF, line limits, full store");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
